### hdl/vrbs_pkg.sv
// Shared types and constants for the variable-length record byte stack.
`default_nettype none

package vrbs_pkg;

    // Store geometry
    localparam int STACK_BYTES  = 1024;
    localparam int HEADER_BYTES = 4;
    localparam int MAX_RECORD   = 64;
    localparam int ADDR_W       = $clog2(STACK_BYTES);
    localparam int PTR_W        = ADDR_W + 1;

    // Field widths
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_RLEN,
        S_RD
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic push;       // push byte transfer accepted
        logic rd_start;   // pull or peek transfer accepted
        logic clear;      // clear transfer accepted
        logic hdr_write;  // commit: write header, move top
        logic len_eval;   // header byte is in read data
        logic byte_out;   // record byte is in read data
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic empty;      // no record stored
        logic commit;     // current push byte completes the record
        logic rd_none;    // read would return no bytes
        logic rd_final;   // current record byte is the last one
    } t_dp_stat;

endpackage

`default_nettype wire

### hdl/variable_record_byte_stack_top.sv
// Top level of the variable-length record byte stack.
//
// Command channel: an item transfers at a rising edge with start high and busy low.
// Result channel: each result is on the o_ ports for one cycle with o_strobe high;
// the receiver cannot stall it, so results never back up.
// Push byte: one result the cycle after the transfer; busy stays low, so push bytes
// stream one per cycle. The last byte of a record holds busy while the length header
// is written via the store's single write port; its result follows the header write.
// Pull/peek: the header is read first, then one record byte per cycle through the
// registered store read port, the last with o_last; the item holds busy through the
// header read and the record byte reads.
// An empty stack or zero bytes to return gives a single result.
// Clear: one result the next cycle, no busy time.
// Reset (synchronous, i_rst_n low) empties the stack and drops any partial push;
// store contents are not cleared, since only committed records are ever read.
`default_nettype none

module variable_record_byte_stack_top
    import vrbs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [BYTE_W-1:0]   i_data_byte,
    input  wire logic [LEN_W-1:0]    i_record_len,
    input  wire logic [LEN_W-1:0]    i_max_len,
    output logic                     o_strobe,
    output logic [STATUS_W-1:0]      o_status,
    output logic [BYTE_W-1:0]        o_data_byte_out,
    output logic                     o_byte_valid,
    output logic                     o_last,
    output logic                     o_is_empty,
    output logic [FREE_W-1:0]        o_free_bytes
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencing
    vrbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Store and arithmetic
    vrbs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_data_byte     (i_data_byte),
        .i_record_len    (i_record_len),
        .i_max_len       (i_max_len),
        .o_stat          (stat),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_data_byte_out (o_data_byte_out),
        .o_byte_valid    (o_byte_valid),
        .o_last          (o_last),
        .o_is_empty      (o_is_empty),
        .o_free_bytes    (o_free_bytes)
    );

endmodule

`default_nettype wire

### hdl/vrbs_ctrl.sv
// Controller state machine for the variable-length record byte stack.
`default_nettype none

module vrbs_ctrl
    import vrbs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire logic [OP_W-1:0] i_op,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_op'(i_op))
                        OP_PUSH: begin
                            o_cmd.push = 1'b1;
                            if (i_stat.commit) n_state = S_HDR;
                        end
                        OP_PULL, OP_PEEK: begin
                            o_cmd.rd_start = 1'b1;
                            if (!i_stat.empty) n_state = S_RLEN;
                        end
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_HDR: begin
                o_cmd.hdr_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_RLEN: begin
                o_cmd.len_eval = 1'b1;
                n_state        = i_stat.rd_none ? S_IDLE : S_RD;
            end
            S_RD: begin
                o_cmd.byte_out = 1'b1;
                if (i_stat.rd_final) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

`ifndef NO_ASSERTIONS
    // A commit writes the header and then always returns to idle
    a_hdr_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR) |=> (r_state == S_IDLE))
        else $error("header write state lasted more than one cycle");

    // Reads only stream after the header length was evaluated
    a_rd_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) && ($past(r_state) != S_RD) |-> ($past(r_state) == S_RLEN))
        else $error("byte streaming entered without header evaluation");

    // Only a push can lead to a header commit
    a_hdr_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDR) |-> ($past(r_state) == S_IDLE) && $past(o_cmd.push))
        else $error("header commit without push");
`endif

endmodule

`default_nettype wire

### hdl/vrbs_dp.sv
// Datapath for the variable-length record byte stack: byte store, pointers, result registers.
`default_nettype none

module vrbs_dp
    import vrbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic [LEN_W-1:0]  i_record_len,
    input  wire logic [LEN_W-1:0]  i_max_len,
    output t_dp_stat               o_stat,
    output logic                   o_strobe,
    output logic [STATUS_W-1:0]    o_status,
    output logic [BYTE_W-1:0]      o_data_byte_out,
    output logic                   o_byte_valid,
    output logic                   o_last,
    output logic                   o_is_empty,
    output logic [FREE_W-1:0]      o_free_bytes
);

    // Byte store and registered read port
    logic [BYTE_W-1:0] r_mem [STACK_BYTES];
    logic [BYTE_W-1:0] r_rdata;

    // Stack and push state
    logic [PTR_W-1:0]  r_top;
    logic [LEN_W-1:0]  r_rem;
    logic              r_drop;
    logic [ADDR_W-1:0] r_wp;
    logic [LEN_W-1:0]  r_plen;

    // Read state
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [LEN_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  r_max_len;
    logic              r_pull;

    // Result registers
    logic                r_strobe;
    logic [STATUS_W-1:0] r_status;
    logic [BYTE_W-1:0]   r_data;
    logic                r_valid;
    logic                r_last;
    logic                r_is_empty;
    logic [PTR_W-1:0]    r_free;

    logic              first;
    logic              len_zero;
    logic [LEN_W-1:0]  len_c;
    logic              full_new;
    logic              drop_path;
    logic              wr_push;
    logic [LEN_W-1:0]  rem_after;
    logic              commit;
    logic [PTR_W-1:0]  push_base;
    logic [PTR_W-1:0]  hdr_ptr;
    logic [LEN_W-1:0]  rd_len;
    logic [LEN_W-1:0]  rd_n;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [PTR_W-1:0]  n_top;
    logic              emit;
    logic [STATUS_W-1:0] emit_status;

    // Push byte decode
    always_comb begin
        first     = (r_rem == '0);
        len_zero  = first && (i_record_len == '0);
        len_c     = (i_record_len > LEN_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD) : i_record_len;
        full_new  = first && !len_zero &&
                    (r_top < (PTR_W'(len_c) + PTR_W'(HEADER_BYTES)));
        drop_path = !first && r_drop;
        wr_push   = !len_zero && !full_new && !drop_path;
        rem_after = first ? (len_c - LEN_W'(1)) : (r_rem - LEN_W'(1));
        commit    = wr_push && (rem_after == '0);
        push_base = r_top - PTR_W'(len_c);
        hdr_ptr   = r_top - PTR_W'(r_plen) - PTR_W'(HEADER_BYTES);
    end

    // Record length from header, limited by the reader
    always_comb begin
        rd_len = (r_rdata > BYTE_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD) : r_rdata[LEN_W-1:0];
        rd_n   = (rd_len < r_max_len) ? rd_len : r_max_len;
    end

    assign o_stat.empty    = (r_top >= PTR_W'(STACK_BYTES));
    assign o_stat.commit   = commit;
    assign o_stat.rd_none  = (rd_n == '0);
    assign o_stat.rd_final = (r_cnt == LEN_W'(1));

    // Store write port: record bytes, then header on commit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wp;
        wr_data = i_data_byte;
        if (i_cmd.push && wr_push) begin
            wr_en   = 1'b1;
            wr_addr = first ? push_base[ADDR_W-1:0] : r_wp;
        end else if (i_cmd.hdr_write) begin
            wr_en   = 1'b1;
            wr_addr = hdr_ptr[ADDR_W-1:0];
            wr_data = BYTE_W'(r_plen);
        end
    end

    // Store read address: header, then record bytes in ascending order
    always_comb begin
        rd_addr = r_rd_ptr;
        if (i_cmd.rd_start) begin
            rd_addr = r_top[ADDR_W-1:0];
        end else if (i_cmd.len_eval) begin
            rd_addr = r_top[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
        end else if (i_cmd.byte_out) begin
            rd_addr = r_rd_ptr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata  <= r_mem[rd_addr];
        r_rd_ptr <= rd_addr;
    end

    // Top of stack after this step
    always_comb begin
        n_top = r_top;
        if (i_cmd.clear) begin
            n_top = PTR_W'(STACK_BYTES);
        end else if (i_cmd.hdr_write) begin
            n_top = hdr_ptr;
        end else if (i_cmd.len_eval && r_pull) begin
            n_top = r_top + PTR_W'(HEADER_BYTES) + PTR_W'(rd_len);
        end
    end

    // Result selection
    always_comb begin
        emit = (i_cmd.push && !commit) || i_cmd.clear || i_cmd.hdr_write ||
               (i_cmd.rd_start && o_stat.empty) ||
               (i_cmd.len_eval && o_stat.rd_none) || i_cmd.byte_out;
        emit_status = ST_OK;
        if (i_cmd.push && (full_new || drop_path)) begin
            emit_status = ST_FULL;
        end else if (i_cmd.rd_start && o_stat.empty) begin
            emit_status = ST_EMPTY;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= PTR_W'(STACK_BYTES);
            r_rem    <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_top    <= n_top;
            r_strobe <= emit;
            if (i_cmd.rd_start || i_cmd.clear) begin
                // any other op abandons a partial record
                r_rem  <= '0;
                r_drop <= 1'b0;
            end else if (i_cmd.push && !len_zero) begin
                r_rem <= rem_after;
                if (full_new) begin
                    r_drop <= 1'b1;
                end else if (first || (rem_after == '0)) begin
                    r_drop <= 1'b0;
                end
            end
        end
    end

    // Push and read bookkeeping, result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && first && !len_zero) r_plen <= len_c;
        if (wr_en && i_cmd.push) r_wp <= wr_addr + ADDR_W'(1);
        if (i_cmd.rd_start) begin
            r_max_len <= i_max_len;
            r_pull    <= (t_op'(i_op) == OP_PULL);
        end
        if (i_cmd.len_eval) begin
            r_cnt <= rd_n;
        end else if (i_cmd.byte_out) begin
            r_cnt <= r_cnt - LEN_W'(1);
        end
        if (emit) begin
            r_status   <= emit_status;
            r_data     <= i_cmd.byte_out ? r_rdata : '0;
            r_valid    <= i_cmd.byte_out;
            r_last     <= i_cmd.byte_out ? o_stat.rd_final : 1'b1;
            r_is_empty <= (n_top >= PTR_W'(STACK_BYTES));
            r_free     <= n_top;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_data_byte_out = r_data;
    assign o_byte_valid    = r_valid;
    assign o_last          = r_last;
    assign o_is_empty      = r_is_empty;
    assign o_free_bytes    = FREE_W'(r_free);

`ifndef NO_ASSERTIONS
    // Top never runs past the end of the store
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= PTR_W'(STACK_BYTES))
        else $error("top pointer beyond store");

    // A committed record plus header fit below the old top
    a_commit_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hdr_write |-> (r_top >= (PTR_W'(r_plen) + PTR_W'(HEADER_BYTES))))
        else $error("commit without room for record and header");

    // Byte streaming never runs with an exhausted count
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.byte_out |-> (r_cnt != '0))
        else $error("record byte emitted with zero count");

    // Pending push length stays within the record limit
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= LEN_W'(MAX_RECORD))
        else $error("pending push length out of range");
`endif

endmodule

`default_nettype wire
